// ----- src/assert_macros.svh -----
// Assertion macros shared by the decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- src/ppm_pkg.sv -----
// Types and constants of the pixmap decoder
package ppm_pkg;
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [14:0] image_width;
        logic [14:0] image_height;
        logic [3:0]  status;
        logic        last;
    } out_item_t;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_MAGIC     = 4'd1;
    localparam logic [3:0] ST_HEADER    = 4'd2;
    localparam logic [3:0] ST_NOPAYLOAD = 4'd3;
    localparam logic [3:0] ST_SEP       = 4'd4;
    localparam logic [3:0] ST_TRUNC     = 4'd5;
    localparam logic [3:0] ST_RANGE     = 4'd6;
    localparam logic [3:0] ST_TOKEN     = 4'd7;
    localparam logic [3:0] ST_LARGE     = 4'd8;

    // work command from the parser to the scaler
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  maxval;
        logic [14:0] w;
        logic [14:0] h;
        logic [3:0]  status;
    } cmd_t;
endpackage

// ----- src/ppm_parser.sv -----
// Front end: byte parser that produces header, pixel and status commands
`include "assert_macros.svh"
module ppm_parser #(
    parameter int MAX_DIMENSION = 16384
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ppm_pkg::in_item_t in_data,
    input  logic              in_valid,
    output logic              in_ready,
    output ppm_pkg::cmd_t     cmd_data,
    output logic              cmd_valid,
    input  logic              cmd_ready
);
    typedef enum logic [2:0] {
        PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_SEP, PH_BIN, PH_ASCII, PH_DONE
    } phase_t;

    localparam logic [14:0] DIM_SAT = 15'(MAX_DIMENSION + 1);
    localparam logic [14:0] DIM_LIM = 15'(MAX_DIMENSION);
    localparam logic [15:0] DIM_MAX = 16'(MAX_DIMENSION);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_P     = 8'h50;

    // progress through the magic token
    localparam logic [15:0] MG_NONE = 16'd0;
    localparam logic [15:0] MG_P    = 16'd1;
    localparam logic [15:0] MG_P3   = 16'd2;
    localparam logic [15:0] MG_P6   = 16'd3;

    phase_t      phase_reg, phase_next;
    logic        ascii_reg, ascii_next;
    logic        cmt_reg, cmt_next;
    logic [15:0] tok_reg, tok_next;
    logic        tstart_reg, tstart_next;
    logic        tbad_reg, tbad_next;
    logic [14:0] w_reg, w_next;
    logic [14:0] h_reg, h_next;
    logic [7:0]  mv_reg, mv_next;
    logic [27:0] left_reg, left_next;
    logic [1:0]  ch_reg, ch_next;
    logic [7:0]  hold0_reg, hold0_next, hold1_reg, hold1_next;
    logic        cr_reg, cr_next;
    // load pixel count: width*height-1, computed in the cycle after the header
    logic        cnt_pend_reg, cnt_pend_next;
    logic [27:0] prod;

    // up to two commands per item; the second waits in slot 1
    ppm_pkg::cmd_t c0, c1;
    logic          e0, e1;
    ppm_pkg::cmd_t q_reg [2];
    logic [1:0]    qn_reg;

    logic       take;
    logic [7:0] c;

    assign in_ready  = (qn_reg == 2'd0) && !cnt_pend_reg;
    assign take      = in_valid && in_ready;
    assign c         = in_data.data_byte;
    assign cmd_valid = (qn_reg != 2'd0);
    assign cmd_data  = q_reg[0];
    assign prod      = {13'd0, w_reg} * {13'd0, h_reg};

    function automatic logic blank(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
    endfunction

    function automatic logic [14:0] sat_dim(input logic [15:0] v);
        return (v > DIM_MAX) ? DIM_SAT : v[14:0];
    endfunction

    always_comb
    begin
        logic [19:0]   acc;
        logic [15:0]   v;
        logic          bad;
        logic          is_text;
        logic          blank_b;
        logic          tok_end_b;
        logic          tok_end;
        logic          sep_chk;
        logic          chan_en;
        logic [7:0]    chan_v;
        logic          fin_en;
        logic [3:0]    fin_code;
        logic          data_en;
        ppm_pkg::cmd_t data_cmd;
        ppm_pkg::cmd_t fin_cmd;
        phase_next = phase_reg; ascii_next = ascii_reg; cmt_next = cmt_reg;
        tok_next = tok_reg; tstart_next = tstart_reg; tbad_next = tbad_reg;
        w_next = w_reg; h_next = h_reg; mv_next = mv_reg; left_next = left_reg;
        ch_next = ch_reg; hold0_next = hold0_reg; hold1_next = hold1_reg;
        cr_next = cr_reg; cnt_pend_next = 1'b0;
        acc = '0; v = '0; bad = 1'b0;
        is_text = (phase_reg != PH_SEP) && (phase_reg != PH_BIN) && (phase_reg != PH_DONE);
        blank_b = 1'b0; tok_end_b = 1'b0; tok_end = 1'b0; sep_chk = 1'b0;
        chan_en = 1'b0; chan_v = '0; fin_en = 1'b0; fin_code = ppm_pkg::ST_OK;
        data_en = 1'b0; data_cmd = '0; fin_cmd = '0;

        if (cnt_pend_reg)
            left_next = prod - 28'd1;

        // byte stage
        if (take && in_data.has_byte)
        begin
            if (phase_reg == PH_SEP)
                sep_chk = 1'b1;
            else if (phase_reg == PH_BIN)
            begin
                cr_next = 1'b0;
                if (!(cr_reg && c == CH_LF))
                begin
                    if (c > mv_reg)
                    begin
                        fin_en = 1'b1; fin_code = ppm_pkg::ST_RANGE;
                    end
                    else
                    begin
                        chan_en = 1'b1; chan_v = c;
                    end
                end
            end
            else if (is_text)
            begin
                if (cmt_reg)
                begin
                    if (c == CH_LF) cmt_next = 1'b0;
                end
                else if (blank(c) || c == CH_HASH)
                begin
                    blank_b = 1'b1;
                    tok_end_b = tstart_reg;
                end
                else
                begin
                    tstart_next = 1'b1;
                    if (phase_reg == PH_MAGIC)
                    begin
                        if (tok_reg == MG_NONE && c == CH_P) tok_next = MG_P;
                        else if (tok_reg == MG_P && c == CH_THREE) tok_next = MG_P3;
                        else if (tok_reg == MG_P && c == CH_SIX) tok_next = MG_P6;
                        else tbad_next = 1'b1;
                    end
                    else if (c >= CH_ZERO && c <= CH_NINE)
                    begin
                        acc = {1'b0, tok_reg, 3'd0} + {3'd0, tok_reg, 1'b0}
                              + {12'd0, c - CH_ZERO};
                        tok_next = (acc > 20'hFFFF) ? 16'hFFFF : acc[15:0];
                    end
                    else tbad_next = 1'b1;
                end
            end
        end

        // close the token on a separator, or on end of stream
        tok_end = tok_end_b
                  || (take && in_data.end_of_stream && is_text && !tok_end_b && tstart_next);
        if (tok_end)
        begin
            v = tok_next; bad = tbad_next;
            tok_next = '0; tstart_next = 1'b0; tbad_next = 1'b0;
            case (phase_reg)
                PH_MAGIC:
                    if (!bad && (v == MG_P3 || v == MG_P6))
                    begin
                        ascii_next = (v == MG_P3); phase_next = PH_WIDTH;
                    end
                    else
                    begin
                        fin_en = 1'b1; fin_code = ppm_pkg::ST_MAGIC;
                    end
                PH_WIDTH:
                    if (bad)
                    begin
                        fin_en = 1'b1; fin_code = ppm_pkg::ST_HEADER;
                    end
                    else
                    begin
                        w_next = sat_dim(v); phase_next = PH_HEIGHT;
                    end
                PH_HEIGHT:
                    if (bad)
                    begin
                        fin_en = 1'b1; fin_code = ppm_pkg::ST_HEADER;
                    end
                    else
                    begin
                        h_next = sat_dim(v); phase_next = PH_MAXVAL;
                    end
                PH_MAXVAL:
                    if (bad || v == 16'd0 || v > 16'd255 || w_reg == '0 || h_reg == '0)
                    begin
                        fin_en = 1'b1; fin_code = ppm_pkg::ST_HEADER;
                    end
                    else if (w_reg > DIM_LIM || h_reg > DIM_LIM)
                    begin
                        fin_en = 1'b1; fin_code = ppm_pkg::ST_LARGE;
                    end
                    else
                    begin
                        mv_next = v[7:0];
                        data_en = 1'b1;
                        data_cmd.kind = ppm_pkg::KIND_HEADER;
                        data_cmd.w = w_reg; data_cmd.h = h_reg;
                        data_cmd.maxval = v[7:0]; data_cmd.status = ppm_pkg::ST_OK;
                        cnt_pend_next = 1'b1; ch_next = '0;
                        phase_next = ascii_reg ? PH_ASCII : PH_SEP;
                    end
                PH_ASCII:
                    if (bad)
                    begin
                        fin_en = 1'b1; fin_code = ppm_pkg::ST_TOKEN;
                    end
                    else if (v > {8'd0, mv_reg})
                    begin
                        fin_en = 1'b1; fin_code = ppm_pkg::ST_RANGE;
                    end
                    else
                    begin
                        chan_en = 1'b1; chan_v = v[7:0];
                    end
                default: ;
            endcase
        end

        // hold two channels, emit a pixel on the third
        if (chan_en)
        begin
            if (ch_reg == 2'd0)
            begin
                hold0_next = chan_v; ch_next = 2'd1;
            end
            else if (ch_reg == 2'd1)
            begin
                hold1_next = chan_v; ch_next = 2'd2;
            end
            else
            begin
                data_en = 1'b1;
                data_cmd.kind = ppm_pkg::KIND_PIXEL;
                data_cmd.r = hold0_reg; data_cmd.g = hold1_reg; data_cmd.b = chan_v;
                data_cmd.maxval = mv_reg; data_cmd.status = ppm_pkg::ST_OK;
                ch_next = 2'd0;
                if (left_reg == '0)
                begin
                    fin_en = 1'b1; fin_code = ppm_pkg::ST_OK;
                end
                else left_next = left_reg - 28'd1;
            end
        end

        // the byte that ends the maxval token is also the binary separator
        if (blank_b && phase_next == PH_SEP)
            sep_chk = 1'b1;
        if (sep_chk)
        begin
            if (!blank(c))
            begin
                fin_en = 1'b1; fin_code = ppm_pkg::ST_SEP;
            end
            else
            begin
                cr_next = (c == CH_CR); phase_next = PH_BIN;
            end
        end
        else if (blank_b && c == CH_HASH && !fin_en)
            cmt_next = 1'b1;

        if (fin_en)
        begin
            phase_next = PH_DONE; cmt_next = 1'b0;
        end

        if (take && in_data.end_of_stream && phase_next != PH_DONE)
        begin
            fin_en = 1'b1;
            case (phase_next)
                PH_MAGIC:                        fin_code = ppm_pkg::ST_MAGIC;
                PH_WIDTH, PH_HEIGHT, PH_MAXVAL:  fin_code = ppm_pkg::ST_HEADER;
                PH_SEP:                          fin_code = ppm_pkg::ST_NOPAYLOAD;
                PH_BIN, PH_ASCII:                fin_code = ppm_pkg::ST_TRUNC;
                default:                         fin_code = ppm_pkg::ST_HEADER;
            endcase
        end

        // status reports the dimensions parsed up to this point
        fin_cmd.kind = ppm_pkg::KIND_STATUS;
        fin_cmd.status = fin_code;
        fin_cmd.w = w_next;
        fin_cmd.h = h_next;
        fin_cmd.maxval = mv_next;

        if (take && in_data.end_of_stream)
        begin
            phase_next = PH_MAGIC; ascii_next = 1'b0; cmt_next = 1'b0;
            tok_next = '0; tstart_next = 1'b0; tbad_next = 1'b0;
            w_next = '0; h_next = '0; mv_next = '0; left_next = '0;
            ch_next = '0; hold0_next = '0; hold1_next = '0; cr_next = 1'b0;
            cnt_pend_next = 1'b0;
        end

        c0 = data_en ? data_cmd : fin_cmd;
        c1 = fin_cmd;
        e0 = data_en || fin_en;
        e1 = data_en && fin_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC; ascii_reg <= 1'b0; cmt_reg <= 1'b0;
            tok_reg <= '0; tstart_reg <= 1'b0; tbad_reg <= 1'b0;
            w_reg <= '0; h_reg <= '0; mv_reg <= '0; left_reg <= '0;
            ch_reg <= '0; hold0_reg <= '0; hold1_reg <= '0; cr_reg <= 1'b0;
            cnt_pend_reg <= 1'b0; qn_reg <= '0;
            q_reg[0] <= '0; q_reg[1] <= '0;
        end
        else
        begin
            phase_reg <= phase_next; ascii_reg <= ascii_next; cmt_reg <= cmt_next;
            tok_reg <= tok_next; tstart_reg <= tstart_next; tbad_reg <= tbad_next;
            w_reg <= w_next; h_reg <= h_next; mv_reg <= mv_next; left_reg <= left_next;
            ch_reg <= ch_next; hold0_reg <= hold0_next; hold1_reg <= hold1_next;
            cr_reg <= cr_next; cnt_pend_reg <= cnt_pend_next;
            if (take)
            begin
                qn_reg <= {1'b0, e0} + {1'b0, e1};
                q_reg[0] <= c0;
                q_reg[1] <= c1;
            end
            else if (cmd_valid && cmd_ready)
            begin
                q_reg[0] <= q_reg[1];
                qn_reg <= qn_reg - 2'd1;
            end
        end
    end

    `ASSERT_IMPLIES(a_no_take_busy, clk, rst_n, qn_reg != 2'd0, !in_ready)
    `ASSERT_NEXT(a_cnt_once, clk, rst_n, cnt_pend_reg, !cnt_pend_reg)
    `ASSERT_IMPLIES(a_ch_range, clk, rst_n, 1'b1, ch_reg != 2'd3)
endmodule

// ----- src/ppm_scaler.sv -----
// Back end: scales channels by 255/maxval and formats results
`include "assert_macros.svh"
module ppm_scaler (
    input  logic               clk,
    input  logic               rst_n,
    input  ppm_pkg::cmd_t      cmd_data,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    output ppm_pkg::out_item_t out_data,
    output logic               out_valid,
    input  logic               out_ready
);
    // one restoring division step per cycle on all three channels
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic [7:0]  mv_reg;
    logic [15:0] num_reg [3];
    logic [7:0]  rem_reg [3];
    logic [6:0]  quo_reg [3];
    logic        ov_reg;

    assign cmd_ready = !busy_reg && !ov_reg;
    assign out_valid = ov_reg;

    // last step of the quotient, taken combinationally
    function automatic logic [7:0] final_q(input logic [1:0] i);
        logic [8:0] r;
        r = {rem_reg[i], num_reg[i][15]};
        return {quo_reg[i], (r >= {1'b0, mv_reg})};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        logic [8:0] r;
        logic [8:0] d;
        if (!rst_n)
        begin
            busy_reg <= 1'b0; ov_reg <= 1'b0; cnt_reg <= '0;
            mv_reg <= '0; out_data <= '0;
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= '0; rem_reg[i] <= '0; quo_reg[i] <= '0;
            end
        end
        else
        begin
            if (ov_reg && out_ready) ov_reg <= 1'b0;
            if (cmd_valid && cmd_ready)
            begin
                mv_reg <= cmd_data.maxval;
                num_reg[0] <= {cmd_data.r, 8'd0} - {8'd0, cmd_data.r};
                num_reg[1] <= {cmd_data.g, 8'd0} - {8'd0, cmd_data.g};
                num_reg[2] <= {cmd_data.b, 8'd0} - {8'd0, cmd_data.b};
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[i] <= '0; quo_reg[i] <= '0;
                end
                cnt_reg <= '0;
                if (cmd_data.kind == ppm_pkg::KIND_PIXEL) busy_reg <= 1'b1;
                else
                begin
                    out_data <= '{kind: cmd_data.kind, red: '0, green: '0, blue: '0,
                        alpha: '0, image_width: cmd_data.w, image_height: cmd_data.h,
                        status: cmd_data.status,
                        last: (cmd_data.kind == ppm_pkg::KIND_STATUS)};
                    ov_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    r = {rem_reg[i], num_reg[i][15]};
                    d = r - {1'b0, mv_reg};
                    num_reg[i] <= {num_reg[i][14:0], 1'b0};
                    if (r >= {1'b0, mv_reg})
                    begin
                        rem_reg[i] <= d[7:0];
                        quo_reg[i] <= {quo_reg[i][5:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[i] <= r[7:0];
                        quo_reg[i] <= {quo_reg[i][5:0], 1'b0};
                    end
                end
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    ov_reg <= 1'b1;
                    out_data <= '{kind: ppm_pkg::KIND_PIXEL, red: final_q(2'd0),
                        green: final_q(2'd1), blue: final_q(2'd2), alpha: 8'hFF,
                        image_width: '0, image_height: '0, status: ppm_pkg::ST_OK,
                        last: 1'b0};
                end
            end
        end
    end

    `ASSERT_IMPLIES(a_busy_no_out, clk, rst_n, busy_reg, !ov_reg)
    `ASSERT_IMPLIES(a_mv_nonzero, clk, rst_n, busy_reg, mv_reg != 8'd0)
    `ASSERT_NEXT(a_out_hold, clk, rst_n, ov_reg && !out_ready, ov_reg)
endmodule

// ----- src/portable_pixmap_decoder.sv -----
// Top level of the pixmap decoder
// Parser takes one byte per cycle while no command waits; a byte that yields a command
// holds input until the scaler takes it. A pixel needs 16 steps in the shift-subtract
// divider, run on all three channels at once; other commands skip the divider.
// The scaler takes a new command only once its result is unloaded: load, steps, unload.
// Reset: rst_n clears all parser and scaler state asynchronously.
module portable_pixmap_decoder #(
    parameter int MAX_DIMENSION = 16384
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ppm_pkg::in_item_t  in_data,
    input  logic               in_valid,
    output logic               in_ready,
    output ppm_pkg::out_item_t out_data,
    output logic               out_valid,
    input  logic               out_ready
);
    ppm_pkg::cmd_t cmd;
    logic          cmd_valid, cmd_ready;

    ppm_parser #(.MAX_DIMENSION(MAX_DIMENSION)) u_parser (
        .clk, .rst_n, .in_data, .in_valid, .in_ready,
        .cmd_data(cmd), .cmd_valid, .cmd_ready
    );

    ppm_scaler u_scaler (
        .clk, .rst_n, .cmd_data(cmd), .cmd_valid, .cmd_ready,
        .out_data, .out_valid, .out_ready
    );
endmodule
